// ===== hdl/c3v_pkg.sv =====
// ----------------------------------------------------------------------------
// c3v_pkg
// Shared types and constants of the 3x3 valid-region convolution stream.
// ----------------------------------------------------------------------------
package c3v_pkg;

    localparam int SAMPLE_BITS       = 16;
    localparam int COEF_BITS         = 16;
    localparam int KERNEL_SIZE       = 3;
    localparam int MAX_WIDTH_DEFAULT = 1024;
    localparam int IMAGE_WIDTH_RESET = 1024;
    localparam int IMAGE_WIDTH_BITS  = 11;
    localparam int MIN_WIDTH         = 3;
    localparam int REG_BITS          = 48;
    localparam int CFG_INDEX_BITS    = 2;
    localparam int FILT_BITS         = 35;
    localparam int PROD_BITS         = SAMPLE_BITS + COEF_BITS;
    localparam int COLSUM_BITS       = PROD_BITS + 2;
    localparam int SUM_BITS          = (COLSUM_BITS + 2 > FILT_BITS) ? COLSUM_BITS + 2
                                                                     : FILT_BITS;
    localparam int FIFO_DEPTH        = 8;
    localparam int FIFO_CNT_BITS     = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_IMAGE_WIDTH   = 2'd0,
        REG_KERNEL_TOP    = 2'd1,
        REG_KERNEL_MIDDLE = 2'd2,
        REG_KERNEL_BOTTOM = 2'd3
    } cfg_reg_t;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [COEF_BITS-1:0]   coef_t;
    typedef sample_t [KERNEL_SIZE-1:0]     column_t;
    typedef coef_t   [KERNEL_SIZE-1:0]     coef_col_t;
    typedef logic signed [COLSUM_BITS-1:0] colsum_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          frame_end;
    } c3v_in_t;

    typedef struct packed {
        logic signed [FILT_BITS-1:0] filtered;
        logic                        row_last;
        logic                        frame_last;
    } c3v_out_t;

endpackage

// ===== hdl/conv3x3_valid_stream_top.sv =====
// ----------------------------------------------------------------------------
// conv3x3_valid_stream_top
// 3x3 valid-region convolution over a raster stream of signed samples.
// ----------------------------------------------------------------------------
// Input items (s_valid/s_ready/s_data) carry one sample and a frame end mark.
// Once two full rows and two samples of the current row are in, every item
// yields one result item (m_valid/m_ready/m_data): the full precision sum of
// the 3x3 window times the kernel, with row and frame end marks.
// Throughput is one item per cycle while s_ready is high. The line store read
// happens at the edge that accepts the item; after it come the window shift,
// the products, the column sums and the final add into the queue, each in
// its own register, and m_valid rises once the result is in the queue.
// Image width and kernel rows are written through cfg_we/cfg_index/cfg_wdata;
// the user must write them only while the block is idle; the block does not enforce it.
// Reset (aresetn low, synchronous) empties the queue and the pipeline, clears
// the row and column counters, and sets width 1024 and a zero kernel.
// When the receiver stalls, results collect in an eight-entry queue; s_ready
// drops once the queue and the items in flight would fill it.
// ----------------------------------------------------------------------------
module conv3x3_valid_stream_top
    import c3v_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  c3v_in_t                   s_data,
    output logic                      m_valid,
    input  logic                      m_ready,
    output c3v_out_t                  m_data,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [REG_BITS-1:0]       cfg_wdata
);

    localparam int CNT_BITS   = $clog2(MAX_WIDTH);
    localparam int WCMP_BITS  = (CNT_BITS + 1 > IMAGE_WIDTH_BITS) ? CNT_BITS + 1
                                                                  : IMAGE_WIDTH_BITS;
    localparam int RESET_LAST = ((IMAGE_WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH
                                                                 : IMAGE_WIDTH_RESET) - 1;
    localparam logic [1:0] ROW_FULL = 2'd2;

    typedef struct packed {
        logic emit;
        logic row_last;
        logic frame_last;
    } flags_t;

    // configuration
    logic [CNT_BITS-1:0]  last_idx_reg, last_idx_next;
    logic [REG_BITS-1:0]  kernel_reg [KERNEL_SIZE];
    logic [WCMP_BITS-1:0] width_in;

    always_comb begin
        width_in = WCMP_BITS'(cfg_wdata[IMAGE_WIDTH_BITS-1:0]);
        if (width_in < WCMP_BITS'(MIN_WIDTH)) begin
            last_idx_next = CNT_BITS'(MIN_WIDTH - 1);
        end else if (width_in > WCMP_BITS'(MAX_WIDTH)) begin
            last_idx_next = CNT_BITS'(MAX_WIDTH - 1);
        end else begin
            last_idx_next = CNT_BITS'(width_in - 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_idx_reg <= CNT_BITS'(RESET_LAST);
            for (int r = 0; r < KERNEL_SIZE; r++) begin
                kernel_reg[r] <= '0;
            end
        end else if (cfg_we) begin
            case (cfg_reg_t'(cfg_index))
                REG_IMAGE_WIDTH:   last_idx_reg  <= last_idx_next;
                REG_KERNEL_TOP:    kernel_reg[0] <= cfg_wdata;
                REG_KERNEL_MIDDLE: kernel_reg[1] <= cfg_wdata;
                REG_KERNEL_BOTTOM: kernel_reg[2] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // input stage: counters and line store read
    logic                s_accept;
    logic [CNT_BITS-1:0] col_cnt_reg, col_cnt_next;
    logic [1:0]          row_cnt_reg, row_cnt_next;
    logic                last_col;
    flags_t              flags0;

    assign s_accept = s_valid && s_ready;
    assign last_col = (col_cnt_reg >= last_idx_reg);

    always_comb begin
        flags0.emit       = (row_cnt_reg == ROW_FULL) && (col_cnt_reg >= CNT_BITS'(2));
        flags0.row_last   = last_col;
        flags0.frame_last = s_data.frame_end;
        col_cnt_next = col_cnt_reg;
        row_cnt_next = row_cnt_reg;
        if (s_data.frame_end) begin
            col_cnt_next = '0;
            row_cnt_next = '0;
        end else if (last_col) begin
            col_cnt_next = '0;
            if (row_cnt_reg < ROW_FULL) begin
                row_cnt_next = row_cnt_reg + 1'b1;
            end
        end else begin
            col_cnt_next = col_cnt_reg + 1'b1;
        end
    end

    // pipeline
    logic                v1_reg, v2_reg, v3_reg, v4_reg;
    flags_t              flags1_reg, flags2_reg, flags3_reg, flags4_reg;
    logic [CNT_BITS-1:0] idx1_reg;
    sample_t             sample1_reg;
    logic                fwd_reg;
    sample_t             fwd_older_reg, fwd_newer_reg;
    logic [SAMPLE_BITS-1:0] older_rdata, newer_rdata;
    sample_t             older_val, newer_val;

    assign older_val = fwd_reg ? fwd_older_reg : sample_t'(older_rdata);
    assign newer_val = fwd_reg ? fwd_newer_reg : sample_t'(newer_rdata);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            fwd_reg     <= 1'b0;
        end else begin
            if (s_accept) begin
                col_cnt_reg <= col_cnt_next;
                row_cnt_reg <= row_cnt_next;
            end
            v1_reg  <= s_accept;
            v2_reg  <= v1_reg;
            v3_reg  <= v2_reg;
            v4_reg  <= v3_reg;
            fwd_reg <= v1_reg && s_accept && (idx1_reg == col_cnt_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            idx1_reg    <= col_cnt_reg;
            sample1_reg <= s_data.sample;
            flags1_reg  <= flags0;
        end
        fwd_older_reg <= newer_val;
        fwd_newer_reg <= sample1_reg;
        flags2_reg    <= flags1_reg;
        flags3_reg    <= flags2_reg;
        flags4_reg    <= flags3_reg;
    end

    // line stores: older takes what newer held, newer takes the new sample
    c3v_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_older_line (
        .aclk  (aclk),
        .we    (v1_reg),
        .waddr (idx1_reg),
        .wdata (newer_val),
        .raddr (col_cnt_reg),
        .rdata (older_rdata)
    );

    c3v_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_newer_line (
        .aclk  (aclk),
        .we    (v1_reg),
        .waddr (idx1_reg),
        .wdata (sample1_reg),
        .raddr (col_cnt_reg),
        .rdata (newer_rdata)
    );

    // window: chain of column cells, newest column enters at the top
    column_t   new_col;
    column_t   col_in  [KERNEL_SIZE];
    column_t   col_out [KERNEL_SIZE];
    colsum_t   col_sum [KERNEL_SIZE];
    coef_col_t coef    [KERNEL_SIZE];

    assign new_col[0] = older_val;
    assign new_col[1] = newer_val;
    assign new_col[2] = sample1_reg;

    for (genvar c = 0; c < KERNEL_SIZE; c++) begin : g_cell
        for (genvar r = 0; r < KERNEL_SIZE; r++) begin : g_coef
            assign coef[c][r] = coef_t'(kernel_reg[r][COEF_BITS*c +: COEF_BITS]);
        end
        if (c == KERNEL_SIZE - 1) begin : g_head
            assign col_in[c] = new_col;
        end else begin : g_link
            assign col_in[c] = col_out[c+1];
        end
        c3v_cell u_cell (
            .aclk     (aclk),
            .shift_en (v1_reg),
            .col_in   (col_in[c]),
            .coef     (coef[c]),
            .col_out  (col_out[c]),
            .col_sum  (col_sum[c])
        );
    end

    // final add and output queue
    logic signed [SUM_BITS-1:0] total;
    c3v_out_t                   result;
    logic                       push, pop;
    logic [FIFO_CNT_BITS-1:0]   fifo_count;
    logic [FIFO_CNT_BITS:0]     credit_used;

    assign total = SUM_BITS'(col_sum[0]) + SUM_BITS'(col_sum[1]) + SUM_BITS'(col_sum[2]);

    always_comb begin
        result.filtered   = total[FILT_BITS-1:0];
        result.row_last   = flags4_reg.row_last;
        result.frame_last = flags4_reg.frame_last;
    end

    assign push = v4_reg && flags4_reg.emit;
    assign pop  = m_valid && m_ready;

    c3v_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (result),
        .pop       (pop),
        .pop_data  (m_data),
        .not_empty (m_valid),
        .count     (fifo_count)
    );

    assign credit_used = (FIFO_CNT_BITS+1)'(fifo_count)
                       + (FIFO_CNT_BITS+1)'(v1_reg) + (FIFO_CNT_BITS+1)'(v2_reg)
                       + (FIFO_CNT_BITS+1)'(v3_reg) + (FIFO_CNT_BITS+1)'(v4_reg);
    assign s_ready = (credit_used < (FIFO_CNT_BITS+1)'(FIFO_DEPTH));

    a_row_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        row_cnt_reg <= ROW_FULL)
        else $error("row counter beyond saturation");

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (fifo_count < FIFO_CNT_BITS'(FIFO_DEPTH)) || pop)
        else $error("result pushed into full queue");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fifo_count <= FIFO_CNT_BITS'(FIFO_DEPTH))
        else $error("queue count out of range");

endmodule

// ===== hdl/c3v_ram.sv =====
// ----------------------------------------------------------------------------
// c3v_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module c3v_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/c3v_cell.sv =====
// ----------------------------------------------------------------------------
// c3v_cell
// One window column: holds three samples, multiplies them by its kernel
// column and sums the products. Shifts its column to the older neighbor.
// ----------------------------------------------------------------------------
module c3v_cell
    import c3v_pkg::*;
(
    input  logic      aclk,
    input  logic      shift_en,
    input  column_t   col_in,
    input  coef_col_t coef,
    output column_t   col_out,
    output colsum_t   col_sum
);

    column_t                     col_reg;
    logic signed [PROD_BITS-1:0] prod_reg [KERNEL_SIZE];
    colsum_t                     sum_reg;

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            col_reg <= col_in;
        end
        for (int r = 0; r < KERNEL_SIZE; r++) begin
            prod_reg[r] <= $signed(col_reg[r]) * $signed(coef[r]);
        end
        sum_reg <= COLSUM_BITS'(prod_reg[0]) + COLSUM_BITS'(prod_reg[1])
                 + COLSUM_BITS'(prod_reg[2]);
    end

    assign col_out = col_reg;
    assign col_sum = sum_reg;

endmodule

// ===== hdl/c3v_fifo.sv =====
// ----------------------------------------------------------------------------
// c3v_fifo
// Small output queue of result items; decouples the pipeline from the sink.
// ----------------------------------------------------------------------------
module c3v_fifo
    import c3v_pkg::*;
#(
    parameter int DEPTH = FIFO_DEPTH
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         push,
    input  c3v_out_t                     push_data,
    input  logic                         pop,
    output c3v_out_t                     pop_data,
    output logic                         not_empty,
    output logic [$clog2(DEPTH+1)-1:0]   count
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    c3v_out_t            mem [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data  = mem[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign count     = count_reg;

endmodule

// ===== tb/conv3x3_valid_stream_top_tb.sv =====
// ----------------------------------------------------------------------------
// conv3x3_valid_stream_top_tb
// Self-checking bench for the 3x3 valid-region convolution stream.
// ----------------------------------------------------------------------------
// A short table of hand-picked items and register writes comes first: the
// sample and kernel extremes, width clamping, a width cut in the middle of a
// row, and frame ends with and without a result. Random frames follow, most
// of them whole frames of random width and kernel, some cut short, plus one
// short frame with a width value at or above the limit. Every accepted item
// runs through a local convolution model, and each result item is checked
// field by field against the oldest pending sum. Both sides stall at random.
// ----------------------------------------------------------------------------
module conv3x3_valid_stream_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import c3v_pkg::*;

    localparam int MAX_W          = MAX_WIDTH_DEFAULT;
    localparam int FULL_ROWS      = KERNEL_SIZE - 1;
    localparam int MAX_GAP        = 8;
    localparam int SETTLE_CYCLES  = 12;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 1000;

    localparam sample_t              PX_MIN       = 16'sh8000;
    localparam sample_t              PX_MAX       = 16'sh7FFF;
    localparam logic [REG_BITS-1:0]  KERN_ALL_MIN = 48'h8000_8000_8000;
    localparam logic [REG_BITS-1:0]  KERN_ALL_MAX = 48'h7FFF_7FFF_7FFF;
    localparam c3v_out_t             NO_SUM       = '0;

    typedef enum logic {
        STEP_PIXEL,
        STEP_WRITE
    } plan_kind_t;

    typedef struct packed {
        plan_kind_t          kind;
        cfg_reg_t            sel;
        logic [REG_BITS-1:0] wdata;
        sample_t             px;
        logic                fend;
        logic                fixed;
        c3v_out_t            fixed_sum;
    } plan_step_t;

    localparam int PLAN_STEPS = 34;

    localparam plan_step_t [0:PLAN_STEPS-1] DIRECTED_PLAN = '{
        '{STEP_WRITE, REG_IMAGE_WIDTH,   48'd4,        '0,     1'b0, 1'b0, NO_SUM},
        '{STEP_WRITE, REG_KERNEL_TOP,    KERN_ALL_MIN, '0,     1'b0, 1'b0, NO_SUM},
        '{STEP_WRITE, REG_KERNEL_MIDDLE, KERN_ALL_MIN, '0,     1'b0, 1'b0, NO_SUM},
        '{STEP_WRITE, REG_KERNEL_BOTTOM, KERN_ALL_MIN, '0,     1'b0, 1'b0, NO_SUM},
        '{STEP_PIXEL, REG_IMAGE_WIDTH,   '0,           PX_MAX, 1'b0, 1'b0, NO_SUM},
        '{STEP_PIXEL, REG_IMAGE_WIDTH,   '0,           PX_MIN, 1'b0, 1'b0, NO_SUM},
        '{STEP_PIXEL, REG_IMAGE_WIDTH,   '0,           16'sd0, 1'b0, 1'b0, NO_SUM},
        '{STEP_PIXEL, REG_IMAGE_WIDTH,   '0,           16'sd1, 1'b0, 1'b0, NO_SUM},
        '{STEP_PIXEL, REG_IMAGE_WIDTH,   '0,           PX_MIN, 1'b0, 1'b0, NO_SUM},
        '{STEP_PIXEL, REG_IMAGE_WIDTH,   '0,           PX_MIN, 1'b0, 1'b0, NO_SUM},
        '{STEP_PIXEL, REG_IMAGE_WIDTH,   '0,           PX_MIN, 1'b0, 1'b0, NO_SUM},
        '{STEP_PIXEL, REG_IMAGE_WIDTH,   '0,           PX_MIN, 1'b0, 1'b0, NO_SUM},
        '{STEP_PIXEL, REG_IMAGE_WIDTH,   '0,           PX_MIN, 1'b0, 1'b0, NO_SUM},
        '{STEP_PIXEL, REG_IMAGE_WIDTH,   '0,           PX_MIN, 1'b0, 1'b0, NO_SUM},
        '{STEP_PIXEL, REG_IMAGE_WIDTH,   '0,           PX_MIN, 1'b0, 1'b0, NO_SUM},
        '{STEP_PIXEL, REG_IMAGE_WIDTH,   '0,           PX_MIN, 1'b0, 1'b0, NO_SUM},
        '{STEP_PIXEL, REG_IMAGE_WIDTH,   '0,           PX_MIN, 1'b0, 1'b0, NO_SUM},
        '{STEP_PIXEL, REG_IMAGE_WIDTH,   '0,           PX_MIN, 1'b0, 1'b0, NO_SUM},
        '{STEP_PIXEL, REG_IMAGE_WIDTH,   '0,           PX_MIN, 1'b1, 1'b1,
          '{35'sd9663676416, 1'b0, 1'b1}},
        '{STEP_PIXEL, REG_IMAGE_WIDTH,   '0,           16'sd0, 1'b1, 1'b0, NO_SUM},
        '{STEP_WRITE, REG_KERNEL_TOP,    KERN_ALL_MAX, '0,     1'b0, 1'b0, NO_SUM},
        '{STEP_WRITE, REG_KERNEL_MIDDLE, KERN_ALL_MAX, '0,     1'b0, 1'b0, NO_SUM},
        '{STEP_WRITE, REG_KERNEL_BOTTOM, KERN_ALL_MAX, '0,     1'b0, 1'b0, NO_SUM},
        '{STEP_PIXEL, REG_IMAGE_WIDTH,   '0,           PX_MIN, 1'b0, 1'b0, NO_SUM},
        '{STEP_PIXEL, REG_IMAGE_WIDTH,   '0,           PX_MIN, 1'b0, 1'b0, NO_SUM},
        '{STEP_PIXEL, REG_IMAGE_WIDTH,   '0,           PX_MIN, 1'b0, 1'b0, NO_SUM},
        '{STEP_WRITE, REG_IMAGE_WIDTH,   48'd0,        '0,     1'b0, 1'b0, NO_SUM},
        '{STEP_PIXEL, REG_IMAGE_WIDTH,   '0,           16'sd5, 1'b0, 1'b0, NO_SUM},
        '{STEP_PIXEL, REG_IMAGE_WIDTH,   '0,           PX_MIN, 1'b0, 1'b0, NO_SUM},
        '{STEP_PIXEL, REG_IMAGE_WIDTH,   '0,           PX_MIN, 1'b0, 1'b0, NO_SUM},
        '{STEP_PIXEL, REG_IMAGE_WIDTH,   '0,           PX_MIN, 1'b0, 1'b0, NO_SUM},
        '{STEP_PIXEL, REG_IMAGE_WIDTH,   '0,           PX_MIN, 1'b0, 1'b0, NO_SUM},
        '{STEP_PIXEL, REG_IMAGE_WIDTH,   '0,           PX_MIN, 1'b0, 1'b0, NO_SUM},
        '{STEP_PIXEL, REG_IMAGE_WIDTH,   '0,           PX_MIN, 1'b1, 1'b1,
          '{-35'sd9663381504, 1'b1, 1'b1}}
    };

    logic                      aclk;
    logic                      aresetn;
    logic                      s_valid;
    logic                      s_ready;
    c3v_in_t                   s_data;
    logic                      m_valid;
    logic                      m_ready;
    c3v_out_t                  m_data;
    logic                      cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [REG_BITS-1:0]       cfg_wdata;

    int unsigned         width_cfg = IMAGE_WIDTH_RESET;
    logic [REG_BITS-1:0] coef_rows [KERNEL_SIZE] = '{default: '0};
    sample_t             hist_far  [MAX_W];
    sample_t             hist_near [MAX_W];
    sample_t             tap [KERNEL_SIZE][KERNEL_SIZE] = '{default: '{default: '0}};
    int unsigned         x_pos  = 0;
    int unsigned         y_fill = 0;

    c3v_out_t    sums_in_flight [$];
    logic        fixed_known;
    c3v_out_t    fixed_sum;
    int unsigned mismatches;
    int unsigned quiet_cycles;
    bit          src_calm;
    bit          sink_calm;

    conv3x3_valid_stream_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    function automatic int unsigned clamp_width(input int unsigned value);
        if (value < MIN_WIDTH) begin
            return MIN_WIDTH;
        end
        if (value > MAX_W) begin
            return MAX_W;
        end
        return value;
    endfunction

    function automatic bit convolve_sample(input sample_t px, input logic fend,
                                           output c3v_out_t res);
        int unsigned                 span;
        int unsigned                 col;
        int unsigned                 slot;
        int                          r;
        int                          k;
        bit                          fire;
        bit                          row_done;
        logic signed [FILT_BITS-1:0] acc;
        span     = clamp_width(width_cfg);
        col      = x_pos;
        slot     = (col < MAX_W) ? col : MAX_W - 1;
        fire     = (y_fill >= FULL_ROWS) && (col >= FULL_ROWS);
        row_done = (col >= span - 1);
        for (r = 0; r < KERNEL_SIZE; r++) begin
            for (k = 0; k < KERNEL_SIZE - 1; k++) begin
                tap[r][k] = tap[r][k+1];
            end
        end
        tap[0][KERNEL_SIZE-1] = hist_far[slot];
        tap[1][KERNEL_SIZE-1] = hist_near[slot];
        tap[2][KERNEL_SIZE-1] = px;
        hist_far[slot]  = hist_near[slot];
        hist_near[slot] = px;
        if (fend) begin
            x_pos  = 0;
            y_fill = 0;
        end else if (row_done) begin
            x_pos = 0;
            if (y_fill < FULL_ROWS) begin
                y_fill++;
            end
        end else begin
            x_pos = col + 1;
        end
        acc = '0;
        for (r = 0; r < KERNEL_SIZE; r++) begin
            for (k = 0; k < KERNEL_SIZE; k++) begin
                acc = acc + tap[r][k] * $signed(coef_rows[r][COEF_BITS*k +: COEF_BITS]);
            end
        end
        res = '{filtered: acc, row_last: row_done, frame_last: fend};
        return fire;
    endfunction

    function automatic logic [15:0] draw_value16();
        logic [31:0] r32;
        r32 = $urandom;
        case ($urandom_range(0, 7))
            0: begin
                return 16'h8000;
            end
            1: begin
                return 16'h7FFF;
            end
            2: begin
                return 16'h0000;
            end
            default: begin
                return r32[15:0];
            end
        endcase
    endfunction

    task automatic flag(input string field, input logic signed [63:0] want,
                        input logic signed [63:0] got);
        $display("%0t mismatch in %s: expected %0d, got %0d", $time, field, want, got);
        mismatches++;
    endtask

    task automatic write_reg(input cfg_reg_t sel, input logic [REG_BITS-1:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= sel;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        case (sel)
            REG_IMAGE_WIDTH: begin
                width_cfg = 32'(val[IMAGE_WIDTH_BITS-1:0]);
            end
            REG_KERNEL_TOP: begin
                coef_rows[0] = val;
            end
            REG_KERNEL_MIDDLE: begin
                coef_rows[1] = val;
            end
            REG_KERNEL_BOTTOM: begin
                coef_rows[2] = val;
            end
            default: begin
            end
        endcase
    endtask

    task automatic load_width(input int unsigned value, output int unsigned span);
        logic [63:0] word;
        word = {$urandom, $urandom};
        word[IMAGE_WIDTH_BITS-1:0] = value[IMAGE_WIDTH_BITS-1:0];
        write_reg(REG_IMAGE_WIDTH, word[REG_BITS-1:0]);
        span = clamp_width(value);
    endtask

    task automatic load_random_kernel();
        write_reg(REG_KERNEL_TOP,    {draw_value16(), draw_value16(), draw_value16()});
        write_reg(REG_KERNEL_MIDDLE, {draw_value16(), draw_value16(), draw_value16()});
        write_reg(REG_KERNEL_BOTTOM, {draw_value16(), draw_value16(), draw_value16()});
    endtask

    // drop valid, drain all pending sums, then let the pipeline empty
    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sums_in_flight.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic send_pixel(input sample_t px, input logic fend, input logic fixed,
                              input c3v_out_t fixed_res);
        int unsigned gap;
        gap = src_calm ? 0 : $urandom_range(0, MAX_GAP);
        @(negedge aclk);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_data      <= '{sample: px, frame_end: fend};
        fixed_known  = fixed;
        fixed_sum    = fixed_res;
        s_valid     <= 1'b1;
        do @(posedge aclk); while (!s_ready);
    endtask

    always @(posedge aclk) begin : scoreboard
        c3v_out_t predicted;
        c3v_out_t wanted;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                if (convolve_sample(s_data.sample, s_data.frame_end, predicted)) begin
                    if (fixed_known) begin
                        predicted = fixed_sum;
                    end
                    sums_in_flight.insert(sums_in_flight.size(), predicted);
                end
            end
            if (m_valid && m_ready) begin
                if (sums_in_flight.size() == 0) begin
                    flag("filtered (nothing pending)", 'x, m_data.filtered);
                end else begin
                    wanted = sums_in_flight.pop_front();
                    if (m_data.filtered !== wanted.filtered) begin
                        flag("filtered", wanted.filtered, m_data.filtered);
                    end
                    if (m_data.row_last !== wanted.row_last) begin
                        flag("row_last", wanted.row_last, m_data.row_last);
                    end
                    if (m_data.frame_last !== wanted.frame_last) begin
                        flag("frame_last", wanted.frame_last, m_data.frame_last);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin : result_sink
        int unsigned stall;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            stall = sink_calm ? 0 : $urandom_range(0, MAX_GAP);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
            if ($urandom_range(0, 31) == 0) begin
                sink_calm = !sink_calm;
            end
        end
    end

    initial begin : stimulus
        plan_step_t  step_now;
        int unsigned done_items;
        int unsigned rows;
        int unsigned len;
        int unsigned frame_w;
        int unsigned width_val;
        int unsigned i;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_data       = '0;
        m_ready      = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_wdata    = '0;
        fixed_known  = 1'b0;
        fixed_sum    = '0;
        mismatches   = 0;
        quiet_cycles = 0;
        src_calm     = 1'b0;
        sink_calm    = 1'b0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (i = 0; i < PLAN_STEPS; i++) begin
            step_now = DIRECTED_PLAN[i];
            if (step_now.kind == STEP_WRITE) begin
                settle();
                write_reg(step_now.sel, step_now.wdata);
            end else begin
                send_pixel(step_now.px, step_now.fend, step_now.fixed, step_now.fixed_sum);
            end
        end

        // whole frames mostly, some cut short by an early frame end
        frame_w    = clamp_width(width_cfg);
        done_items = 0;
        while (done_items < RANDOM_ITEMS) begin
            src_calm = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 1) == 0) begin
                settle();
                case ($urandom_range(0, 7))
                    0: begin
                        width_val = $urandom_range(0, MIN_WIDTH - 1);
                    end
                    1: begin
                        width_val = MIN_WIDTH;
                    end
                    default: begin
                        width_val = $urandom_range(MIN_WIDTH + 1, 12);
                    end
                endcase
                load_width(width_val, frame_w);
                load_random_kernel();
            end
            rows = $urandom_range(FULL_ROWS + 1, 5);
            len  = rows * frame_w;
            if ($urandom_range(0, 4) == 0) begin
                len = $urandom_range(1, len);
            end
            for (i = 0; i < len; i++) begin
                send_pixel(draw_value16(), i == len - 1, 1'b0, NO_SUM);
            end
            done_items += len;
        end

        // a short frame with the width register at or above the limit
        settle();
        src_calm = ($urandom_range(0, 1) == 0);
        load_width($urandom_range(MAX_W, (1 << IMAGE_WIDTH_BITS) - 1), frame_w);
        load_random_kernel();
        len = $urandom_range(3, 8);
        for (i = 0; i < len; i++) begin
            send_pixel(draw_value16(), i == len - 1, 1'b0, NO_SUM);
        end

        settle();
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
